// ===== design/terrain_triangle_height_sample_core_assert.svh =====
// Assertion macros used by the checker of the terrain height sampler.
`ifndef TERRAIN_TRIANGLE_HEIGHT_SAMPLE_CORE_ASSERT_SVH
`define TERRAIN_TRIANGLE_HEIGHT_SAMPLE_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TTHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define TTHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define TTHS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tths_pkg.sv =====
// Shared constants and types of the terrain height sampler.
package tths_pkg;

    localparam int MaxCorners = 4096;
    localparam int AddrW      = 12;
    localparam int HeightW    = 16;
    localparam int CoordW     = 16;
    localparam int TileW      = 8;
    localparam int GridW      = 6;
    localparam int StrideW    = GridW + 1;
    localparam int OffW       = TileW + 1;
    localparam int CfgIdxW    = 2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_TILE_SIZE   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT = 2'd2;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Where a query point falls relative to the grid.
    typedef enum logic [1:0] {
        REG_INSIDE,
        REG_RIGHT,
        REG_TOP,
        REG_CORNER
    } t_region;

    // One classified item passed from the front end to the back end.
    typedef struct packed {
        logic                      is_query;
        logic [AddrW-1:0]          addr;
        logic signed [HeightW-1:0] value;
        t_region                   region;
        logic                      du_top;
        logic                      dv_right;
        logic signed [OffW-1:0]    u;
        logic signed [OffW-1:0]    v;
        logic [TileW-1:0]          ts;
        logic [StrideW-1:0]        stride;
    } t_item;

endpackage

// ===== design/terrain_triangle_height_sample_core.sv =====
// Terrain height sampler: a query passes the front and back ends into the result queue.
// Front: divide by the tile size; back: corner read, multiplies and a divide. The back
// end takes no new item until the result of its current query is queued.
// A corner write is accepted every cycle while full is low and is stored when the
// back is idle. Synchronous active-low reset clears the queues and sequencers, and sets
// tile size to 16 and grid size to 63 by 63; corner heights are undefined until written.
module terrain_triangle_height_sample_core
    import tths_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_index,
    input  logic [TileW-1:0]          i_cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_command,
    input  logic [AddrW-1:0]          i_corner_addr,
    input  logic signed [HeightW-1:0] i_corner_value,
    input  logic signed [CoordW-1:0]  i_pos_x,
    input  logic signed [CoordW-1:0]  i_pos_y,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [HeightW-1:0] o_height
);

    logic [TileW-1:0] r_tile_size;
    logic [GridW-1:0] r_grid_width;
    logic [GridW-1:0] r_grid_height;
    logic             item_valid;
    logic             item_pop;
    t_item            item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size   <= TileW'(16);
            r_grid_width  <= GridW'(63);
            r_grid_height <= GridW'(63);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TILE_SIZE:   r_tile_size   <= i_cfg_data;
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GridW-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GridW-1:0];
                default: ;
            endcase
        end
    end

    tths_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_corner_addr  (i_corner_addr),
        .i_corner_value (i_corner_value),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_tile_size    (r_tile_size),
        .i_grid_width   (r_grid_width),
        .i_grid_height  (r_grid_height),
        .o_item_valid   (item_valid),
        .o_item         (item),
        .i_item_pop     (item_pop)
    );

    tths_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .empty        (empty),
        .pop          (pop),
        .o_height     (o_height)
    );

endmodule

// ===== design/tths_front.sv =====
// Front end: accepts items, divides the query point by the tile size and classifies it.
module tths_front
    import tths_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_command,
    input  logic [AddrW-1:0]          i_corner_addr,
    input  logic signed [HeightW-1:0] i_corner_value,
    input  logic signed [CoordW-1:0]  i_pos_x,
    input  logic signed [CoordW-1:0]  i_pos_y,
    input  logic [TileW-1:0]          i_tile_size,
    input  logic [GridW-1:0]          i_grid_width,
    input  logic [GridW-1:0]          i_grid_height,
    output logic                      o_item_valid,
    output t_item                     o_item,
    input  logic                      i_item_pop
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate            r_state, n_state;
    logic [3:0]         r_cnt;
    logic [CoordW-1:0]  r_qx, r_qy;
    logic [TileW-1:0]   r_rx, r_ry;
    logic               r_negx, r_negy;
    logic [TileW-1:0]   r_ts;
    t_item              r_q_mem [2];
    logic               r_q_wp, r_q_rp;
    logic [1:0]         r_q_cnt;

    logic               accept;
    logic               q_push, q_pop;
    t_item              q_data;
    logic [TileW:0]     remx9, remy9;
    logic               gex, gey;
    logic [CoordW-1:0]  ix, iy;
    logic signed [OffW-1:0] ux, uy;
    logic               past_r, past_t;
    logic [GridW-1:0]   col, row;
    logic [StrideW-1:0] stride;
    logic [12:0]        base;
    logic               parity, sel_even, sel_odd;
    logic signed [OffW:0] uv_sum;
    t_item              q_item;

    assign full         = !(r_state == F_IDLE && r_q_cnt != 2'd2);
    assign accept       = push && !full;
    assign o_item_valid = (r_q_cnt != 2'd0);
    assign o_item       = r_q_mem[r_q_rp];
    assign q_pop        = i_item_pop && o_item_valid;

    // One restoring divide step on each coordinate.
    assign remx9 = {r_rx, r_qx[CoordW-1]};
    assign remy9 = {r_ry, r_qy[CoordW-1]};
    assign gex   = (remx9 >= {1'b0, r_ts});
    assign gey   = (remy9 >= {1'b0, r_ts});

    // Classify the query from quotient and remainder.
    always_comb begin
        ix = r_negx ? '0 : r_qx;
        iy = r_negy ? '0 : r_qy;
        if (!r_negx) begin
            ux = $signed({1'b0, r_rx});
        end else if (r_qx != '0) begin
            ux = '0;
        end else begin
            ux = -$signed({1'b0, r_rx});
        end
        if (!r_negy) begin
            uy = $signed({1'b0, r_ry});
        end else if (r_qy != '0) begin
            uy = '0;
        end else begin
            uy = -$signed({1'b0, r_ry});
        end
        past_r = (ix >= {{(CoordW-GridW){1'b0}}, i_grid_width});
        past_t = (iy >= {{(CoordW-GridW){1'b0}}, i_grid_height});
        col    = past_r ? i_grid_width  : ix[GridW-1:0];
        row    = past_t ? i_grid_height : iy[GridW-1:0];
        stride = {1'b0, i_grid_width} + StrideW'(1);
        base   = 13'(row) * 13'(stride) + 13'(col);
        parity = ix[0] ^ iy[0];
        uv_sum = $signed({ux[OffW-1], ux}) + $signed({uy[OffW-1], uy});
        sel_even = (ux > uy);
        sel_odd  = (uv_sum < $signed({2'b00, r_ts}));

        q_item          = '0;
        q_item.is_query = 1'b1;
        q_item.addr     = base[AddrW-1:0];
        q_item.u        = ux;
        q_item.v        = uy;
        q_item.ts       = r_ts;
        q_item.stride   = stride;
        if (past_r && past_t) begin
            q_item.region = REG_CORNER;
        end else if (past_r) begin
            q_item.region = REG_RIGHT;
        end else if (past_t) begin
            q_item.region = REG_TOP;
        end else begin
            q_item.region = REG_INSIDE;
        end
        if (!parity) begin
            q_item.du_top   = !sel_even;
            q_item.dv_right = sel_even;
        end else begin
            q_item.du_top   = !sel_odd;
            q_item.dv_right = !sel_odd;
        end
    end

    // Queue write side: writes go in at accept, queries after the divide.
    always_comb begin
        q_push = 1'b0;
        q_data = q_item;
        if (accept && i_command == CMD_WRITE) begin
            q_push         = 1'b1;
            q_data         = '0;
            q_data.addr    = i_corner_addr;
            q_data.value   = i_corner_value;
        end else if (r_state == F_PUSH) begin
            q_push = 1'b1;
        end
    end

    // Next state of the front sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept && i_command == CMD_QUERY) n_state = F_DIV;
            end
            F_DIV: begin
                if (r_cnt == 4'd15) n_state = F_PUSH;
            end
            F_PUSH:  n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == F_DIV) ? r_cnt + 4'd1 : 4'd0;
            if (q_push) r_q_wp <= !r_q_wp;
            if (q_pop)  r_q_rp <= !r_q_rp;
            r_q_cnt <= r_q_cnt + 2'(q_push) - 2'(q_pop);
        end
    end

    // Divider datapath and queue storage.
    always_ff @(posedge i_clk) begin
        if (q_push) r_q_mem[r_q_wp] <= q_data;
        if (accept && i_command == CMD_QUERY) begin
            r_negx <= i_pos_x[CoordW-1];
            r_negy <= i_pos_y[CoordW-1];
            r_qx   <= i_pos_x[CoordW-1] ? CoordW'(-i_pos_x) : i_pos_x;
            r_qy   <= i_pos_y[CoordW-1] ? CoordW'(-i_pos_y) : i_pos_y;
            r_rx   <= '0;
            r_ry   <= '0;
            r_ts   <= (i_tile_size == '0) ? TileW'(1) : i_tile_size;
        end else if (r_state == F_DIV) begin
            r_qx <= {r_qx[CoordW-2:0], gex};
            r_qy <= {r_qy[CoordW-2:0], gey};
            r_rx <= gex ? TileW'(remx9 - {1'b0, r_ts}) : remx9[TileW-1:0];
            r_ry <= gey ? TileW'(remy9 - {1'b0, r_ts}) : remy9[TileW-1:0];
        end
    end

endmodule

// ===== design/tths_back.sv =====
// Back end: corner store, four-corner read, plane evaluation and result queue.
module tths_back
    import tths_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    input  t_item                     i_item,
    output logic                      o_item_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [HeightW-1:0] o_height
);

    localparam int ProdW = HeightW + 1 + OffW;
    localparam int AccW  = ProdW + 1;
    localparam int ResW  = AccW + 2;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_READ = 6'b000010,
        B_MUL1 = 6'b000100,
        B_MUL2 = 6'b001000,
        B_DIV  = 6'b010000,
        B_OUT  = 6'b100000
    } t_bstate;

    t_bstate                   r_state, n_state;
    logic [4:0]                r_cnt;
    t_item                     r_cur;
    logic signed [HeightW-1:0] r_mem [MaxCorners];
    logic signed [HeightW-1:0] r_rd_data;
    logic signed [HeightW-1:0] r_crn [4];
    logic signed [AccW-1:0]    r_acc;
    logic                      r_neg;
    logic [AccW-1:0]           r_dq;
    logic [TileW-1:0]          r_rem;
    logic signed [HeightW-1:0] r_o_mem [2];
    logic                      r_o_wp, r_o_rp;
    logic [1:0]                r_o_cnt;

    logic [AddrW-1:0]          rd_addr;
    logic signed [HeightW:0]   du, dv;
    logic signed [ProdW-1:0]   prod_u, prod_v;
    logic signed [AccW-1:0]    sum;
    logic [TileW:0]            rem9;
    logic                      ge;
    logic signed [ResW-1:0]    res;
    logic signed [HeightW-1:0] sat;
    logic                      o_push, o_pop;
    logic                      mem_we;

    assign o_item_pop = (r_state == B_IDLE) && i_item_valid;
    assign mem_we     = o_item_pop && !i_item.is_query;
    assign empty      = (r_o_cnt == 2'd0);
    assign o_height   = r_o_mem[r_o_rp];
    assign o_pop      = pop && !empty;
    assign o_push     = (r_state == B_OUT) && (r_o_cnt != 2'd2);

    // Read address of bottom-left, bottom-right, top-left and top-right corner.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    rd_addr = r_cur.addr;
            2'd1:    rd_addr = r_cur.addr + AddrW'(1);
            2'd2:    rd_addr = r_cur.addr + AddrW'(r_cur.stride);
            default: rd_addr = r_cur.addr + AddrW'(r_cur.stride) + AddrW'(1);
        endcase
    end

    // Plane slopes of the chosen triangle or edge.
    always_comb begin
        du = r_cur.du_top ? (HeightW+1)'(r_crn[3]) - (HeightW+1)'(r_crn[2])
                          : (HeightW+1)'(r_crn[1]) - (HeightW+1)'(r_crn[0]);
        dv = r_cur.dv_right ? (HeightW+1)'(r_crn[3]) - (HeightW+1)'(r_crn[1])
                            : (HeightW+1)'(r_crn[2]) - (HeightW+1)'(r_crn[0]);
        case (r_cur.region)
            REG_INSIDE: ;
            REG_RIGHT: begin
                du = '0;
                dv = (HeightW+1)'(r_crn[2]) - (HeightW+1)'(r_crn[0]);
            end
            REG_TOP: begin
                du = (HeightW+1)'(r_crn[1]) - (HeightW+1)'(r_crn[0]);
                dv = '0;
            end
            default: begin
                du = '0;
                dv = '0;
            end
        endcase
    end

    // Products, divide step and final saturation.
    always_comb begin
        prod_u = r_cur.u * du;
        prod_v = r_cur.v * dv;
        sum    = r_acc + AccW'(prod_v);
        rem9   = {r_rem, r_dq[AccW-1]};
        ge     = (rem9 >= {1'b0, r_cur.ts});
        res    = ResW'(r_crn[0]) + (r_neg ? -$signed({2'b00, r_dq}) : $signed({2'b00, r_dq}));
        if (res > ResW'(32767)) begin
            sat = 16'sh7fff;
        end else if (res < -ResW'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = res[HeightW-1:0];
        end
    end

    // Next state of the back sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (o_item_pop && i_item.is_query) n_state = B_READ;
            end
            B_READ: begin
                if (r_cnt == 5'd4) n_state = B_MUL1;
            end
            B_MUL1: n_state = B_MUL2;
            B_MUL2: n_state = B_DIV;
            B_DIV: begin
                if (r_cnt == 5'(AccW - 1)) n_state = B_OUT;
            end
            B_OUT: begin
                if (o_push) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_cnt   <= '0;
            r_o_wp  <= 1'b0;
            r_o_rp  <= 1'b0;
            r_o_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_READ || r_state == B_DIV) begin
                r_cnt <= (n_state == r_state) ? r_cnt + 5'd1 : 5'd0;
            end else begin
                r_cnt <= '0;
            end
            if (o_push) r_o_wp <= !r_o_wp;
            if (o_pop)  r_o_rp <= !r_o_rp;
            r_o_cnt <= r_o_cnt + 2'(o_push) - 2'(o_pop);
        end
    end

    // Corner store.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[i_item.addr] <= i_item.value;
        r_rd_data <= r_mem[rd_addr];
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_item_pop) r_cur <= i_item;
        if (r_state == B_READ && r_cnt != 5'd0) r_crn[2'(r_cnt - 5'd1)] <= r_rd_data;
        if (r_state == B_MUL1) r_acc <= AccW'(prod_u);
        if (r_state == B_MUL2) begin
            r_neg <= sum[AccW-1];
            r_dq  <= sum[AccW-1] ? AccW'(-sum) : AccW'(sum);
            r_rem <= '0;
        end else if (r_state == B_DIV) begin
            r_dq  <= {r_dq[AccW-2:0], ge};
            r_rem <= ge ? TileW'(rem9 - {1'b0, r_cur.ts}) : rem9[TileW-1:0];
        end
        if (o_push) r_o_mem[r_o_wp] <= sat;
    end

endmodule

// ===== design/tths_checker.sv =====
// Port-level checker of the terrain height sampler and its bind.
`include "terrain_triangle_height_sample_core_assert.svh"

module tths_checker
    import tths_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      push,
    input logic                      full,
    input logic                      i_command,
    input logic                      empty,
    input logic                      pop,
    input logic signed [HeightW-1:0] o_height
);

    // The result queue is empty right after reset.
    `TTHS_ASSERT_ALWAYS_NEXT(a_empty_after_reset, i_clk, !i_rst_n, empty, "result queue not empty after reset")

    // A waiting result holds until it is taken.
    `TTHS_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_height), "waiting result changed")

    // An accepted query keeps the front busy in the next cycle.
    `TTHS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, push && !full && i_command == CMD_QUERY, full, "front took an item during a divide")

endmodule

bind terrain_triangle_height_sample_core tths_checker u_tths_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .push      (push),
    .full      (full),
    .i_command (i_command),
    .empty     (empty),
    .pop       (pop),
    .o_height  (o_height)
);
